>>> hw/rtl/rfrc_pkg.sv
// ----------------------------------------------------------------------------
// Ring frame receive classifier package
// Shared types, register indexes, codes and constants of the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rfrc_pkg;

   // Configuration port geometry.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_STATION_ADDRESS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BCAST_ADDRESS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOKEN_MARKER    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAT_SERVICE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_SERVICE    = 3'd4;

   // Register reset values.
   localparam logic [4:0] STATION_ADDRESS_RST = 5'd1;
   localparam logic [4:0] BCAST_ADDRESS_RST   = 5'd15;
   localparam logic [7:0] TOKEN_MARKER_RST    = 8'd255;
   localparam logic [2:0] CHAT_SERVICE_RST    = 3'd1;
   localparam logic [2:0] TIME_SERVICE_RST    = 3'd3;

   // Route codes.
   localparam logic [1:0] ROUTE_TOKEN    = 2'd0;
   localparam logic [1:0] ROUTE_DATABACK = 2'd1;
   localparam logic [1:0] ROUTE_FORWARD  = 2'd2;

   // Delivery codes.
   localparam logic [1:0] DELIVER_NONE = 2'd0;
   localparam logic [1:0] DELIVER_CHAT = 2'd1;
   localparam logic [1:0] DELIVER_TIME = 2'd2;

   // Status byte flags.
   localparam logic [7:0] STATUS_READ_BIT = 8'h02;
   localparam logic [7:0] STATUS_ACK_BIT  = 8'h01;

   // Source, destination and length precede the payload.
   localparam logic [8:0] HEADER_BYTES = 9'd3;

   // Configuration register set.
   typedef struct packed {
      logic [4:0] station_address;
      logic [4:0] bcast_address;
      logic [7:0] token_marker;
      logic [2:0] chat_service;
      logic [2:0] time_service;
   } cfg_type;

   // One result transaction.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_done;
      logic       is_payload;
      logic [1:0] route;
      logic [1:0] deliver_to;
      logic [4:0] source_address;
      logic [2:0] source_service;
   } result_type;

endpackage : rfrc_pkg

`default_nettype wire

>>> hw/rtl/rfrc_req_if.sv
// ----------------------------------------------------------------------------
// Ring frame byte request channel
// Valid/ready channel that carries one received frame byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       marks_end;

   modport source (output valid, output in_byte, output marks_end, input ready);
   modport sink   (input valid, input in_byte, input marks_end, output ready);
endinterface : rfrc_req_if

`default_nettype wire

>>> hw/rtl/rfrc_rsp_if.sv
// ----------------------------------------------------------------------------
// Ring frame byte result channel
// Valid/ready channel that carries one classified byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_done;
   logic       is_payload;
   logic [1:0] route;
   logic [1:0] deliver_to;
   logic [4:0] source_address;
   logic [2:0] source_service;

   modport source (
      output valid, output out_byte, output frame_done, output is_payload,
      output route, output deliver_to, output source_address,
      output source_service, input ready
   );
   modport sink (
      input valid, input out_byte, input frame_done, input is_payload,
      input route, input deliver_to, input source_address,
      input source_service, output ready
   );
endinterface : rfrc_rsp_if

`default_nettype wire

>>> hw/rtl/ring_frame_receive_classifier_core.sv
// ----------------------------------------------------------------------------
// Ring frame receive classifier core
// Classifies received ring frame bytes and flags read, ack, route and delivery.
// ----------------------------------------------------------------------------
// The core takes one frame byte per request transaction and returns exactly
// one result transaction for it from a registered output. A new byte
// can be taken in every cycle: classification is a single pass of compares
// and a 6-bit add on the frame tracker state, and results wait in an output
// register backed by one skid slot, so a byte is still accepted while one
// result waits to be taken and only two unread results hold off the request
// side. Configuration registers are written through the csr port and take
// effect on the next byte; indexes beyond the register list are ignored.
`default_nettype none

module ring_frame_receive_classifier_core
   import rfrc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   rfrc_req_if.sink                    req_if,
   rfrc_rsp_if.source                  rsp_if,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   result_type result;
   result_type out_ff;
   result_type skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       accept;
   logic       pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.station_address <= STATION_ADDRESS_RST;
         cfg_ff.bcast_address   <= BCAST_ADDRESS_RST;
         cfg_ff.token_marker    <= TOKEN_MARKER_RST;
         cfg_ff.chat_service    <= CHAT_SERVICE_RST;
         cfg_ff.time_service    <= TIME_SERVICE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STATION_ADDRESS: cfg_ff.station_address <= csr_wdata[4:0];
            CSR_BCAST_ADDRESS:   cfg_ff.bcast_address   <= csr_wdata[4:0];
            CSR_TOKEN_MARKER:    cfg_ff.token_marker    <= csr_wdata;
            CSR_CHAT_SERVICE:    cfg_ff.chat_service    <= csr_wdata[2:0];
            CSR_TIME_SERVICE:    cfg_ff.time_service    <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // Handshakes: requests stall only when the skid slot is occupied.
   assign req_if.ready = !skid_valid_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign pop          = out_valid_ff && rsp_if.ready;

   rfrc_frame_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_if.in_byte),
      .marks_end (req_if.marks_end),
      .cfg       (cfg_ff),
      .result    (result)
   );

   // Output register with one skid slot behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (accept) begin
            out_ff <= result;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end else begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.out_byte       = out_ff.out_byte;
   assign rsp_if.frame_done     = out_ff.frame_done;
   assign rsp_if.is_payload     = out_ff.is_payload;
   assign rsp_if.route          = out_ff.route;
   assign rsp_if.deliver_to     = out_ff.deliver_to;
   assign rsp_if.source_address = out_ff.source_address;
   assign rsp_if.source_service = out_ff.source_service;

   // The skid slot is only used behind a full output register.
   a_skid_order : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot holds a result ahead of the output register");

   // A transaction taken while the output stalls must land in the skid slot.
   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      (accept && out_valid_ff && !rsp_if.ready) |=> skid_valid_ff)
      else $error("result lost behind a stalled output");

   // Route, delivery and source fields stay clear away from the frame end.
   a_fields_idle : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.frame_done) |->
         ((out_ff.route == ROUTE_TOKEN) && (out_ff.deliver_to == DELIVER_NONE)
          && (out_ff.source_address == '0) && (out_ff.source_service == '0)))
      else $error("frame end fields set on a byte inside the frame");

   // Delivery is flagged only together with the ack bit.
   a_deliver_ack : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.deliver_to != DELIVER_NONE)) |->
         ((out_ff.out_byte & STATUS_ACK_BIT) != '0))
      else $error("delivery flagged without the ack bit");

endmodule : ring_frame_receive_classifier_core

`default_nettype wire

>>> hw/rtl/rfrc_frame_tracker.sv
// ----------------------------------------------------------------------------
// Ring frame tracker
// Holds the per-frame state and classifies the presented byte in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrc_frame_tracker
   import rfrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   input  wire logic       marks_end,
   input  wire cfg_type    cfg,
   output      result_type result
);

   logic [8:0] byte_index_ff, byte_index_in;
   logic [7:0] payload_length_ff, payload_length_in;
   logic [5:0] running_sum_ff, running_sum_in;
   logic [7:0] source_byte_ff, source_byte_in;
   logic [7:0] destination_byte_ff, destination_byte_in;
   logic       in_token_ff, in_token_in;

   logic [8:0] payload_end;
   logic [4:0] dst_addr;
   logic [2:0] dst_sapi;
   logic [4:0] src_addr;
   logic       restart;

   assign payload_end = HEADER_BYTES + {1'b0, payload_length_ff};
   assign dst_addr    = destination_byte_ff[7:3];
   assign dst_sapi    = destination_byte_ff[2:0];
   assign src_addr    = source_byte_ff[7:3];

   // Classify the byte and work out the next frame state.
   always_comb begin
      byte_index_in       = byte_index_ff;
      payload_length_in   = payload_length_ff;
      running_sum_in      = running_sum_ff;
      source_byte_in      = source_byte_ff;
      destination_byte_in = destination_byte_ff;
      in_token_in         = in_token_ff;
      restart             = 1'b0;

      result                = '0;
      result.out_byte       = in_byte;
      result.route          = ROUTE_TOKEN;
      result.deliver_to     = DELIVER_NONE;

      if ((byte_index_ff == '0) && !in_token_ff && (in_byte == cfg.token_marker)) begin
         // A token opens.
         in_token_in   = 1'b1;
         byte_index_in = 9'd1;
      end else if (in_token_ff) begin
         // Token bytes pass through unchanged.
         in_token_in = 1'b1;
      end else if (byte_index_ff < HEADER_BYTES) begin
         // Header bytes: source, destination, length.
         if (byte_index_ff == 9'd0) begin
            source_byte_in = in_byte;
         end else if (byte_index_ff == 9'd1) begin
            destination_byte_in = in_byte;
         end else begin
            payload_length_in = in_byte;
         end
         running_sum_in = running_sum_ff + in_byte[5:0];
         byte_index_in  = byte_index_ff + 9'd1;
      end else if (byte_index_ff < payload_end) begin
         // Payload bytes.
         running_sum_in    = running_sum_ff + in_byte[5:0];
         result.is_payload = 1'b1;
         byte_index_in     = byte_index_ff + 9'd1;
      end else begin
         // Status byte closes a data frame.
         if ((dst_addr == cfg.station_address) || (dst_addr == cfg.bcast_address)) begin
            result.out_byte = result.out_byte | STATUS_READ_BIT;
            if (in_byte[7:2] == running_sum_ff) begin
               result.out_byte = result.out_byte | STATUS_ACK_BIT;
               if (dst_sapi == cfg.chat_service) begin
                  result.deliver_to = DELIVER_CHAT;
               end else if (dst_sapi == cfg.time_service) begin
                  result.deliver_to = DELIVER_TIME;
               end
            end
         end
         result.route          = (src_addr == cfg.station_address) ? ROUTE_DATABACK
                                                                    : ROUTE_FORWARD;
         result.source_address = src_addr;
         result.source_service = source_byte_ff[2:0];
         result.frame_done     = 1'b1;
         restart               = 1'b1;
      end

      // The end mark closes a token, including a token of one byte.
      if (in_token_in && marks_end) begin
         result.frame_done = 1'b1;
         result.route      = ROUTE_TOKEN;
         restart           = 1'b1;
      end

      if (restart) begin
         byte_index_in       = '0;
         payload_length_in   = '0;
         running_sum_in      = '0;
         source_byte_in      = '0;
         destination_byte_in = '0;
         in_token_in         = 1'b0;
      end
   end

   // Frame state advances on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff       <= '0;
         payload_length_ff   <= '0;
         running_sum_ff      <= '0;
         source_byte_ff      <= '0;
         destination_byte_ff <= '0;
         in_token_ff         <= 1'b0;
      end else if (accept) begin
         byte_index_ff       <= byte_index_in;
         payload_length_ff   <= payload_length_in;
         running_sum_ff      <= running_sum_in;
         source_byte_ff      <= source_byte_in;
         destination_byte_ff <= destination_byte_in;
         in_token_ff         <= in_token_in;
      end
   end

   // A token always sits at index one.
   a_token_index : assert property (@(posedge clock) disable iff (reset)
      in_token_ff |-> (byte_index_ff == 9'd1))
      else $error("token active with byte index other than one");

   // The index never runs past the status byte of the current frame.
   a_index_bound : assert property (@(posedge clock) disable iff (reset)
      !in_token_ff |-> (byte_index_ff <= payload_end))
      else $error("byte index beyond the status byte");

endmodule : rfrc_frame_tracker

`default_nettype wire
